// ===== rtl/ttg_pkg.sv =====
// shared constants and codes for the thermistor temperature gradient block
package ttg_pkg;

  // sample width default
  localparam int SampleBitsDefault = 12;

  // status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO     = 2'd1,
    STAT_NONPOS   = 2'd2,
    STAT_RESERVED = 2'd3
  } ttg_status_t;

  // register indexes
  localparam logic REG_BIAS     = 1'b0;
  localparam logic REG_INTERVAL = 1'b1;

  // register reset values
  localparam logic signed [14:0] BiasReset     = 15'sd5400;
  localparam logic [5:0]         IntervalReset = 6'd1;

  // arithmetic constants
  localparam logic [13:0] ResOffset  = 14'd10000;
  localparam logic [29:0] Ln2Q30     = 30'd744261118;
  localparam logic [57:0] CoefAShift = 58'd11291480000 << 20;
  localparam logic [31:0] CoefB      = 32'd2341250000;
  localparam logic [31:0] CoefC      = 32'd876741;
  localparam logic [59:0] KelvinNum  = 60'd1024000000000000000;
  localparam logic [20:0] ZeroC100   = 21'd27315;
  localparam logic [30:0] OneQ30     = 31'h4000_0000;
  localparam logic [4:0]  LastTerm   = 5'd23;

endpackage

// ===== rtl/thermistor_temperature_gradient_core.sv =====
// thermistor to temperature and gradient conversion core
// the run time for a good sample is set by the shared restoring divider
//   (one quotient bit per cycle, 15 divisions), the series loop and the normalize shift
// a zero sample goes straight to the output stage, a non-positive resistance ends after the first division
// throughput: one item at a time, the next taken in the cycle after the current one is in the
//   output register; rst (synchronous) restores bias 5400, interval 1, previous temperature 0
module thermistor_temperature_gradient_core #(
  parameter int SAMPLE_BITS = ttg_pkg::SampleBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  // sample channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        adc_sample,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [17:0] temperature,
  output logic signed [17:0] gradient,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ttg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DIVR, S_NORM, S_DIVZ, S_MZZ, S_MPSET, S_MP, S_DIVP,
    S_MK, S_ML2, S_ML3, S_MB, S_MC, S_DIVK, S_TGR, S_DIVG, S_FIN
  } state_t;

  state_t state;

  // configuration registers
  logic signed [14:0] bias;
  logic [5:0]         interval;
  logic signed [17:0] prev;

  // divider registers
  logic [63:0] dnum;
  logic [47:0] dden;
  logic [47:0] drem;
  logic [63:0] quo;
  logic [6:0]  dcnt;

  // multiplier operands
  logic [33:0] ma;
  logic [31:0] mb;

  // datapath registers
  logic [30:0]        x;
  logic [4:0]         shcnt;
  logic [4:0]         kk;
  logic [29:0]        z2;
  logic [29:0]        p;
  logic [30:0]        ssum;
  logic [4:0]         n;
  logic [24:0]        lq;
  logic [33:0]        l3;
  logic [57:0]        acc;
  logic signed [20:0] temp;
  logic               neg;
  logic [1:0]         rstat;
  logic [17:0]        rtemp;
  logic [17:0]        rgrad;

  // combinational helpers
  logic [48:0] rem_sh;
  logic        ge;
  logic [65:0] mprod;
  logic [11:0] smp;
  logic [35:0] ln_sum;
  logic [24:0] lq_next;
  logic [29:0] l2_next;
  logic [29:0] p_next;
  logic [63:0] acc_next;
  logic signed [21:0] diff;
  logic [21:0] mag;
  logic [5:0]  iv;
  logic        cfg_wr;

  // shared restoring divider step
  assign rem_sh = {drem, dnum[63]};
  assign ge     = rem_sh >= {1'b0, dden};

  // shared multiplier
  assign mprod = 66'(ma) * 66'(mb);

  assign smp      = 12'(adc_sample[SAMPLE_BITS-1:0]);
  assign ln_sum   = 36'(mprod[35:0]) + 36'({ssum, 1'b0});
  assign lq_next  = 25'((ln_sum + 36'd512) >> 10);
  assign l2_next  = 30'(mprod >> 20);
  assign p_next   = 30'(mprod >> 30);
  assign acc_next = 64'(acc) + mprod[63:0];
  assign diff     = 22'(temp) - 22'(prev);
  assign mag      = diff[21] ? 22'(-diff) : 22'(diff);
  assign iv       = (interval == 6'd0) ? 6'd1 : interval;

  // handshake
  assign in_ready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;

  // register read back
  always_comb begin
    case (paddr[2])
      REG_BIAS:     prdata = 32'(bias);
      REG_INTERVAL: prdata = 32'(interval);
      default:      prdata = 32'd0;
    endcase
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      dcnt      <= 7'd0;
      bias      <= BiasReset;
      interval  <= IntervalReset;
      prev      <= 18'sd0;
    end else begin
      // divider runs while bits remain
      if (dcnt != 7'd0) begin
        drem <= ge ? 48'(rem_sh - {1'b0, dden}) : 48'(rem_sh);
        quo  <= {quo[62:0], ge};
        dnum <= dnum << 1;
        dcnt <= dcnt - 7'd1;
      end

      // result beat taken
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rtemp <= 18'd0;
            rgrad <= 18'd0;
            if (smp == 12'd0) begin
              rstat <= STAT_ZERO;
              state <= S_FIN;
            end else begin
              dnum  <= 64'(ResOffset) << 50;
              dden  <= 48'(smp);
              drem  <= 48'd0;
              quo   <= 64'd0;
              dcnt  <= 7'(SAMPLE_BITS + 14);
              state <= S_DIVR;
            end
          end
        end
        S_DIVR: begin
          if (dcnt == 7'd0) begin
            if (quo <= 64'(ResOffset)) begin
              rstat <= STAT_NONPOS;
              state <= S_FIN;
            end else begin
              x     <= 31'(quo - 64'(ResOffset));
              shcnt <= 5'd0;
              state <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (x[30]) begin
            kk    <= 5'(5'd30 - shcnt);
            dnum  <= 64'(x[29:0]) << 34;
            dden  <= 48'(x) + 48'(OneQ30);
            drem  <= 48'd0;
            quo   <= 64'd0;
            dcnt  <= 7'd60;
            state <= S_DIVZ;
          end else begin
            x     <= x << 1;
            shcnt <= shcnt + 5'd1;
          end
        end
        S_DIVZ: begin
          if (dcnt == 7'd0) begin
            ma    <= 34'(quo[29:0]);
            mb    <= 32'(quo[29:0]);
            p     <= quo[29:0];
            ssum  <= 31'(quo[29:0]);
            n     <= 5'd3;
            state <= S_MZZ;
          end
        end
        S_MZZ: begin
          z2    <= p_next;
          state <= S_MPSET;
        end
        S_MPSET: begin
          ma    <= 34'(p);
          mb    <= 32'(z2);
          state <= S_MP;
        end
        // next series power, then divide by its odd index
        S_MP: begin
          p     <= p_next;
          dnum  <= 64'(p_next) << 34;
          dden  <= 48'(n);
          drem  <= 48'd0;
          quo   <= 64'd0;
          dcnt  <= 7'd30;
          state <= S_DIVP;
        end
        S_DIVP: begin
          if (dcnt == 7'd0) begin
            ssum <= ssum + 31'(quo[29:0]);
            if (n == LastTerm) begin
              ma    <= 34'(kk);
              mb    <= 32'(Ln2Q30);
              state <= S_MK;
            end else begin
              n     <= n + 5'd2;
              state <= S_MPSET;
            end
          end
        end
        S_MK: begin
          lq    <= lq_next;
          ma    <= 34'(lq_next);
          mb    <= 32'(lq_next);
          state <= S_ML2;
        end
        S_ML2: begin
          ma    <= 34'(l2_next);
          mb    <= 32'(lq);
          state <= S_ML3;
        end
        S_ML3: begin
          l3    <= 34'(mprod >> 20);
          ma    <= 34'(lq);
          mb    <= CoefB;
          state <= S_MB;
        end
        S_MB: begin
          acc   <= CoefAShift + 58'(mprod);
          ma    <= l3;
          mb    <= CoefC;
          state <= S_MC;
        end
        // reciprocal with rounding
        S_MC: begin
          dden  <= 48'(acc_next >> 10);
          dnum  <= 64'(KelvinNum + 60'(acc_next >> 11)) << 4;
          drem  <= 48'd0;
          quo   <= 64'd0;
          dcnt  <= 7'd60;
          state <= S_DIVK;
        end
        S_DIVK: begin
          if (dcnt == 7'd0) begin
            temp  <= $signed(21'(quo[19:0]) - ZeroC100 + 21'(bias));
            state <= S_TGR;
          end
        end
        S_TGR: begin
          neg   <= diff[21];
          dnum  <= 64'(mag[20:0]) << 43;
          dden  <= 48'(iv);
          drem  <= 48'd0;
          quo   <= 64'd0;
          dcnt  <= 7'd21;
          state <= S_DIVG;
        end
        S_DIVG: begin
          if (dcnt == 7'd0) begin
            rgrad <= neg ? 18'(-quo[20:0]) : 18'(quo[20:0]);
            rtemp <= 18'(temp);
            rstat <= STAT_OK;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= rstat;
            temperature <= $signed(rtemp);
            gradient    <= $signed(rgrad);
            if (rstat == STAT_OK) begin
              prev <= $signed(rtemp);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // configuration writes
      if (cfg_wr) begin
        case (paddr[2])
          REG_BIAS:     bias <= $signed(pwdata[14:0]);
          REG_INTERVAL: interval <= pwdata[5:0];
          default:      ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/ttg_checker.sv =====
// port-level checks for the thermistor temperature gradient core
module ttg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic signed [17:0] temperature,
  input logic signed [17:0] gradient
);
  import ttg_pkg::*;

  // error results carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STAT_OK) |-> (temperature == 18'sd0 && gradient == 18'sd0))
    else $error("error result with nonzero fields");

  // busy after a sample beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sample taken while busy");

  // no result beat right after a sample beat
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid) |=> !out_valid)
    else $error("result appeared without work");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(temperature) && $stable(gradient)))
    else $error("stalled result changed");

endmodule

bind thermistor_temperature_gradient_core ttg_checker u_ttg_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .temperature(temperature), .gradient(gradient)
);

// ===== test/testbench.sv =====
// self-checking testbench for the thermistor temperature gradient core
`timescale 1ns / 100ps

module testbench;
  import ttg_pkg::*;

  localparam int NumRandom = 1620;
  localparam int LongHold  = 1500;
  localparam logic [2:0] AddrBias     = {1'b0, REG_BIAS, 2'b00};
  localparam logic [2:0] AddrInterval = {1'b0, REG_INTERVAL, 2'b00};

  typedef struct {
    ttg_status_t       stat;
    logic signed [17:0] temp;
    logic signed [17:0] grad;
  } reading_t;

  typedef struct {
    logic [11:0]        sample;
    bit                 typed;
    ttg_status_t        stat;
    logic signed [17:0] temp;
    logic signed [17:0] grad;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [11:0] adc_sample;
  logic out_valid;
  logic out_ready;
  logic [1:0] status;
  logic signed [17:0] temperature;
  logic signed [17:0] gradient;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // predictor copy of registers and stored temperature
  logic signed [14:0] model_bias;
  logic [5:0]         model_interval;
  logic signed [17:0] model_prev_temp;

  reading_t expected_readings[$];
  int  mismatches;
  int  beats_in;
  int  beats_out;
  int  error_beats;
  bit  quiet;
  bit  long_hold;
  bit  row_typed;
  reading_t row_reading;

  thermistor_temperature_gradient_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .adc_sample(adc_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .temperature(temperature), .gradient(gradient),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // natural log in q30, odd atanh series up to the 23rd power
  function automatic longint unsigned log_q30(longint unsigned r);
    int unsigned k;
    longint unsigned x, z, z2, p, s;
    k = 0;
    while (k < 31 && (r >> (k + 1)) != 0) k++;
    x = r << (30 - k);
    z = ((x - 64'd1073741824) << 30) / (x + 64'd1073741824);
    z2 = (z * z) >> 30;
    s = z;
    p = z;
    for (int n = 3; n <= 23; n += 2) begin
      p = (p * z2) >> 30;
      s += p / n;
    end
    return longint'(k) * 64'd744261118 + 2 * s;
  endfunction

  // expected reading for one sample, advancing the stored temperature
  function automatic reading_t convert_sample(logic [11:0] sample);
    reading_t rd;
    longint res, temp, iv;
    longint unsigned lq, l2, l3, dsum, d, k100;
    rd.stat = STAT_OK;
    rd.temp = '0;
    rd.grad = '0;
    if (sample == 0) begin
      rd.stat = STAT_ZERO;
      return rd;
    end
    res = longint'(64'd40960000 / sample) - 10000;
    if (res <= 0) begin
      rd.stat = STAT_NONPOS;
      return rd;
    end
    lq = (log_q30(res) + 512) >> 10;
    l2 = (lq * lq) >> 20;
    l3 = (l2 * lq) >> 20;
    dsum = (64'd11291480000 << 20) + 64'd2341250000 * lq + 64'd876741 * l3;
    d = dsum >> 10;
    k100 = (64'd1024000000000000000 + d / 2) / d;
    temp = longint'(k100) - 27315 + longint'(model_bias);
    iv = (model_interval == 0) ? 1 : longint'(model_interval);
    rd.temp = temp[17:0];
    rd.grad = 18'((temp - longint'(model_prev_temp)) / iv);
    model_prev_temp = temp[17:0];
    return rd;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // monitor at the falling edge: beats complete at the next rising edge
  always @(negedge clk) begin
    reading_t want, pred;
    if (!rst) begin
      if (psel && penable && pwrite) begin
        if (paddr == AddrBias) model_bias = pwdata[14:0];
        else if (paddr == AddrInterval) model_interval = pwdata[5:0];
      end
      if (in_valid && in_ready) begin
        pred = convert_sample(adc_sample);
        expected_readings.push_back(row_typed ? row_reading : pred);
        beats_in++;
      end
      if (out_valid && out_ready) begin
        beats_out++;
        if (status != STAT_OK) error_beats++;
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected beat status", status, -1);
        end else begin
          want = expected_readings.pop_front();
          if (status != want.stat) report_mismatch("status", status, want.stat);
          if (temperature != want.temp) report_mismatch("temperature", temperature, want.temp);
          if (gradient != want.grad) report_mismatch("gradient", gradient, want.grad);
        end
      end
    end
  end

  // receiver: random stalls, one long hold to back the block up
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(logic [11:0] sample);
    bit taken;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    adc_sample <= sample;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [11:0] random_sample();
    case ($urandom_range(0, 19))
      0:       return 12'd0;
      1:       return 12'hfff;
      2:       return 12'(($urandom_range(1, 8)));
      3:       return 12'(4096 - $urandom_range(1, 8));
      default: return 12'($urandom_range(1, 4095));
    endcase
  endfunction

  // directed rows, zero samples have typed results
  row_t directed[] = '{
    '{12'd0,    1'b1, STAT_ZERO, 18'sd0, 18'sd0},
    '{12'd1,    1'b0, STAT_OK,   18'sd0, 18'sd0},
    '{12'd2,    1'b0, STAT_OK,   18'sd0, 18'sd0},
    '{12'd4095, 1'b0, STAT_OK,   18'sd0, 18'sd0},
    '{12'd0,    1'b1, STAT_ZERO, 18'sd0, 18'sd0},
    '{12'd4094, 1'b0, STAT_OK,   18'sd0, 18'sd0},
    '{12'd2048, 1'b0, STAT_OK,   18'sd0, 18'sd0},
    '{12'd1024, 1'b0, STAT_OK,   18'sd0, 18'sd0},
    '{12'haaa,  1'b0, STAT_OK,   18'sd0, 18'sd0},
    '{12'h555,  1'b0, STAT_OK,   18'sd0, 18'sd0},
    '{12'd3000, 1'b0, STAT_OK,   18'sd0, 18'sd0},
    '{12'd100,  1'b0, STAT_OK,   18'sd0, 18'sd0},
    '{12'd1,    1'b0, STAT_OK,   18'sd0, 18'sd0},
    '{12'd4095, 1'b0, STAT_OK,   18'sd0, 18'sd0},
    '{12'd0,    1'b1, STAT_ZERO, 18'sd0, 18'sd0}
  };

  // register settings per phase, a zero interval included
  int bias_set[]     = '{10000, -10000, 0, 5400, -1, 1234, -7777, 9999};
  int interval_set[] = '{60, 1, 0, 7, 33, 60, 1, 13};

  // stimulus
  initial begin
    int per_phase;
    rst = 1'b1;
    in_valid = 1'b0;
    adc_sample = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet = 1'b0;
    long_hold = 1'b0;
    row_typed = 1'b0;
    mismatches = 0;
    beats_in = 0;
    beats_out = 0;
    error_beats = 0;
    model_bias = 15'sd5400;
    model_interval = 6'd1;
    model_prev_temp = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part with reset settings
    foreach (directed[i]) begin
      row_typed = directed[i].typed;
      row_reading.stat = directed[i].stat;
      row_reading.temp = directed[i].temp;
      row_reading.grad = directed[i].grad;
      send_sample(directed[i].sample);
    end
    row_typed = 1'b0;
    drain();

    // random phases, each under its own register setting
    per_phase = NumRandom / bias_set.size();
    foreach (bias_set[p]) begin
      write_reg(AddrBias, 32'(bias_set[p]));
      write_reg(AddrInterval, 32'(interval_set[p]));
      if (p == 1) long_hold = 1'b1;
      if (p == bias_set.size() - 1) quiet = 1'b1;
      for (int n = 0; n < per_phase; n++) send_sample(random_sample());
      drain();
    end

    repeat (50) @(posedge clk);
    $display("samples sent %0d, readings checked %0d, error readings %0d", beats_in, beats_out,
             error_beats);
    $display("covered %0d register settings incl. bias and interval extremes", bias_set.size());
    if (mismatches == 0) begin
      $display("thermistor_temperature_gradient_core test passed");
    end else begin
      $display("thermistor_temperature_gradient_core test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    $display("thermistor_temperature_gradient_core test failed");
    $finish;
  end

endmodule
